// ----- hw/rtl/mm3_pkg.sv -----
// Package for the MurmurHash3 x86_32 stream hasher: constants, types and
// small bit helpers shared by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mm3_pkg;

    // Mixing constants.
    localparam logic [31:0] C1     = 32'hcc9e2d51;
    localparam logic [31:0] C2     = 32'h1b873593;
    localparam logic [31:0] MIXADD = 32'he6546b64;
    localparam logic [31:0] F1     = 32'h85ebca6b;
    localparam logic [31:0] F2     = 32'hc2b2ae35;

    // Stream and register port geometry.
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 3;
    localparam int TDATA_W = 40;
    localparam int ADDR_W  = 3;
    localparam int IDX_W   = ADDR_W - 2;

    localparam logic [CNT_W-1:0] FULL_CNT = 3'd4;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_SEED = 1'b0;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL1  = 7'b0000010,
        ST_MUL2  = 7'b0000100,
        ST_MIX   = 7'b0001000,
        ST_FIN   = 7'b0010000,
        ST_FMIX1 = 7'b0100000,
        ST_FMIX2 = 7'b1000000
    } state_t;

    // Controller to datapath commands, one per step.
    typedef struct packed {
        logic load;   // capture a new word
        logic mul1;   // k *= C1
        logic mul2;   // k = rotl(k,15) * C2
        logic mix;    // fold k into running hash, update length
        logic fin;    // x = h ^ len, x ^= x >> 16
        logic fmix1;  // x *= F1, x ^= x >> 13
        logic fmix2;  // x *= F2, x ^= x >> 16, write result register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last;   // word in flight closes the key
    } status_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

    // Keeps the valid low bytes of a tail word.
    function automatic logic [31:0] tail_mask(input logic [CNT_W-1:0] cnt);
        case (cnt)
            3'd0:    tail_mask = 32'h00000000;
            3'd1:    tail_mask = 32'h000000ff;
            3'd2:    tail_mask = 32'h0000ffff;
            3'd3:    tail_mask = 32'h00ffffff;
            default: tail_mask = 32'hffffffff;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mm3_datapath.sv -----
// Datapath for the MurmurHash3 hasher: seed register, running hash, length,
// work register and one shared 32x32 multiplier. Uses mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm3_datapath (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mm3_pkg::cmd_t              cmd,
    input  wire logic [mm3_pkg::WORD_W-1:0] in_word,
    input  wire logic [mm3_pkg::CNT_W-1:0]  in_count,
    input  wire logic                       in_last,
    input  wire logic                       cfg_we,
    input  wire logic [31:0]                cfg_wdata,
    output logic [31:0]                     seed,
    output logic [31:0]                     result,
    output mm3_pkg::status_t                status
);

    logic [31:0]               seed_reg;
    logic [31:0]               hash_reg;
    logic [31:0]               len_reg;
    logic [31:0]               work_reg;
    logic [31:0]               out_reg;
    logic [mm3_pkg::CNT_W-1:0] cnt_reg;
    logic                      last_reg;
    logic                      open_reg;

    logic [mm3_pkg::CNT_W-1:0] cnt_eff;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [31:0]               prod;
    logic [31:0]               mixed;
    logic [31:0]               hash_mix;
    logic [31:0]               fin_x;

    // Short words count as full unless they close the key.
    assign cnt_eff = (!in_last || in_count > mm3_pkg::FULL_CNT) ? mm3_pkg::FULL_CNT : in_count;

    // Shared multiplier operand select.
    always_comb begin
        mul_a = work_reg;
        mul_b = mm3_pkg::C1;
        if (cmd.mul2) begin
            mul_a = mm3_pkg::rotl15(work_reg);
            mul_b = mm3_pkg::C2;
        end else if (cmd.fmix1) begin
            mul_b = mm3_pkg::F1;
        end else if (cmd.fmix2) begin
            mul_b = mm3_pkg::F2;
        end
    end

    assign prod = mul_a * mul_b;

    // Block mix: xor, rotate 13, times 5 plus constant; a tail word is only xored in.
    assign mixed = mm3_pkg::rotl13(hash_reg ^ work_reg);
    assign hash_mix = (cnt_reg == mm3_pkg::FULL_CNT)
                    ? (mixed + {mixed[29:0], 2'b00} + mm3_pkg::MIXADD)
                    : (hash_reg ^ work_reg);
    assign fin_x = hash_reg ^ len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            open_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
            end
            if (cmd.load) begin
                open_reg <= 1'b1;
            end else if (cmd.mix && last_reg) begin
                open_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            work_reg <= in_word & mm3_pkg::tail_mask(cnt_eff);
            cnt_reg  <= cnt_eff;
            last_reg <= in_last;
            if (!open_reg) begin
                hash_reg <= seed_reg;
                len_reg  <= '0;
            end
        end
        if (cmd.mul1 || cmd.mul2) begin
            work_reg <= prod;
        end
        if (cmd.mix) begin
            hash_reg <= hash_mix;
            len_reg  <= len_reg + {{(32 - mm3_pkg::CNT_W){1'b0}}, cnt_reg};
        end
        if (cmd.fin) begin
            work_reg <= fin_x ^ {16'h0000, fin_x[31:16]};
        end
        if (cmd.fmix1) begin
            work_reg <= prod ^ {13'h0000, prod[31:13]};
        end
        if (cmd.fmix2) begin
            out_reg <= prod ^ {16'h0000, prod[31:16]};
        end
    end

    assign seed        = seed_reg;
    assign result      = out_reg;
    assign status.last = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mm3_ctrl.sv -----
// Controller for the MurmurHash3 hasher: step sequencer and result valid flag.
// Uses mm3_pkg; drives mm3_datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module mm3_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire mm3_pkg::status_t  status,
    output mm3_pkg::cmd_t          cmd
);

    mm3_pkg::state_t state_reg;
    mm3_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            in_xfer;
    logic            slot_free;

    assign in_ready  = (state_reg == mm3_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            mm3_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    cmd.load   = 1'b1;
                    state_next = mm3_pkg::ST_MUL1;
                end
            end
            mm3_pkg::ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = mm3_pkg::ST_MUL2;
            end
            mm3_pkg::ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = mm3_pkg::ST_MIX;
            end
            mm3_pkg::ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = status.last ? mm3_pkg::ST_FIN : mm3_pkg::ST_IDLE;
            end
            mm3_pkg::ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = mm3_pkg::ST_FMIX1;
            end
            mm3_pkg::ST_FMIX1: begin
                cmd.fmix1  = 1'b1;
                state_next = mm3_pkg::ST_FMIX2;
            end
            mm3_pkg::ST_FMIX2: begin
                // hold here until the result register is free
                if (slot_free) begin
                    cmd.fmix2      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mm3_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mm3_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mm3_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // An accepted word always starts the multiply sequence.
    a_load_to_mul1: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == mm3_pkg::ST_MUL1)
        else $error("accepted word did not enter first multiply");

    // A new result only appears after the last finalizer step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || out_ready) ##1 out_valid_reg
        |-> $past(state_reg == mm3_pkg::ST_FMIX2))
        else $error("result raised outside final step");

    // Finalizer waits while an untaken result occupies the register.
    a_fmix2_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mm3_pkg::ST_FMIX2 && out_valid_reg && !out_ready)
        |=> state_reg == mm3_pkg::ST_FMIX2 && out_valid_reg)
        else $error("result overwritten before transfer");

    // A word that does not close the key returns straight to idle after mixing.
    a_mix_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mm3_pkg::ST_MIX && !status.last) |=> state_reg == mm3_pkg::ST_IDLE)
        else $error("non-final word entered finalizer");

endmodule

`default_nettype wire

// ----- hw/rtl/murmur3_hash32.sv -----
// Top level of the MurmurHash3 x86_32 stream hasher: stream ports, register
// port decode, mm3_ctrl and mm3_datapath. Uses mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Port group  | Dir | Carries
// ------------+-----+---------------------------------------------------------
// s_t*        | in  | key words: tdata {byte_count[34:32], data_word[31:0]}, tlast
// m_t*        | out | one finished hash per key: tdata {hash_value[31:0]}
// p*          | in  | register port, seed at byte address 0
//
// Steps: a word not closing the key passes transfer, two multiplies and mix
//   before the next tready; the closing word adds the xor-shift and two
//   finalizer multiplies. All multiplies go through one shared 32x32
//   multiplier, one step per cycle unless the last finalizer step stalls.
// Reset: synchronous active-low; seed clears to 0, no key open, no result.
// Stalls: the result sits in an output register, so the next key is taken
//   while it waits; only a second result stalls the last finalizer step.

module murmur3_hash32 (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [mm3_pkg::TDATA_W-1:0] s_tdata,  // data_word[31:0], byte_count[34:32], 0
    input  wire logic                        s_tlast,  // last word of the key
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [mm3_pkg::WORD_W-1:0]       m_tdata,  // hash_value[31:0]
    // register port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mm3_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    mm3_pkg::cmd_t    cmd;
    mm3_pkg::status_t status;
    logic             cfg_we;
    logic [31:0]      seed;
    logic             seed_sel;

    // Register decode: index taken from the word address bits.
    assign pready   = 1'b1;
    assign seed_sel = (paddr[mm3_pkg::ADDR_W-1:2] == mm3_pkg::REG_SEED);
    assign cfg_we   = psel && penable && pwrite && pready && seed_sel;
    assign prdata   = seed_sel ? seed : 32'h00000000;

    mm3_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mm3_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_word   (s_tdata[mm3_pkg::WORD_W-1:0]),
        .in_count  (s_tdata[mm3_pkg::WORD_W+mm3_pkg::CNT_W-1:mm3_pkg::WORD_W]),
        .in_last   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata),
        .seed      (seed),
        .result    (m_tdata),
        .status    (status)
    );

endmodule

`default_nettype wire
